FILE: hdl/hrhp_pkg.sv
package hrhp_pkg;

   // Field widths of one transaction on each channel.
   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned STATUS_W      = 16;
   localparam int unsigned CTYPE_LEN_W   = 8;
   localparam int unsigned BODY_LEN_BITS = 24;
   localparam int unsigned KIND_W        = 2;

   // Longest content-type value that is passed on.
   localparam logic [CTYPE_LEN_W-1:0] CTYPE_MAX = 8'd255;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_CTYPE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BODY    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

   // Special characters.
   localparam logic [BYTE_W-1:0] CR_BYTE    = 8'd13;
   localparam logic [BYTE_W-1:0] LF_BYTE    = 8'd10;
   localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
   localparam logic [BYTE_W-1:0] ZERO_CHAR  = 8'h30;
   localparam logic [BYTE_W-1:0] NINE_CHAR  = 8'h39;

   // Header name that is matched, one character per position.
   localparam logic [3:0] NAME_LEN = 4'd13;

   // One result transaction.
   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [BYTE_W-1:0]        out_byte;
      logic [CTYPE_LEN_W-1:0]   ctype_index;
      logic [STATUS_W-1:0]      status_code;
      logic [CTYPE_LEN_W-1:0]   ctype_length;
      logic [BODY_LEN_BITS-1:0] body_length;
      logic                     ok;
      logic                     run_end;
   } result_type;

   // Character of "Content-Type:" at a given position.
   function automatic logic [BYTE_W-1:0] name_char(input logic [3:0] pos);
      logic [BYTE_W-1:0] c;
      unique case (pos)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6f; // o
         4'd2:    c = 8'h6e; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6e; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2d; // -
         4'd8:    c = 8'h54; // T
         4'd9:    c = 8'h79; // y
         4'd10:   c = 8'h70; // p
         4'd11:   c = 8'h65; // e
         4'd12:   c = 8'h3a; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: hdl/http_response_header_parser.sv
// A result is written into a four-entry result queue and offered on the rsp_ port from there.
// Throughput: one byte per cycle while req_ready is high; the parse state is updated in a single pass per byte.
// A last byte that also yields a value or body byte gives two results, drained one per
// cycle while rsp_ready is high from the result queue; req_ready falls while fewer than two entries are free.
// Reset is synchronous and active high; it returns the parse state to the version field
// and empties the result queue.
module http_response_header_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [hrhp_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                               req_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [hrhp_pkg::KIND_W-1:0]        rsp_kind,
   output logic [hrhp_pkg::BYTE_W-1:0]        rsp_out_byte,
   output logic [hrhp_pkg::CTYPE_LEN_W-1:0]   rsp_ctype_index,
   output logic [hrhp_pkg::STATUS_W-1:0]      rsp_status_code,
   output logic [hrhp_pkg::CTYPE_LEN_W-1:0]   rsp_ctype_length,
   output logic [hrhp_pkg::BODY_LEN_BITS-1:0] rsp_body_length,
   output logic                               rsp_ok,
   output logic                               rsp_run_end
);
   import hrhp_pkg::*;

   // Parse phases.
   localparam logic [3:0] PH_VERSION     = 4'd0;
   localparam logic [3:0] PH_DIGITS      = 4'd1;
   localparam logic [3:0] PH_STATUS_REST = 4'd2;
   localparam logic [3:0] PH_NAME        = 4'd3;
   localparam logic [3:0] PH_LINE_CR     = 4'd4;
   localparam logic [3:0] PH_LINE_REST   = 4'd5;
   localparam logic [3:0] PH_SPACES      = 4'd6;
   localparam logic [3:0] PH_VALUE       = 4'd7;
   localparam logic [3:0] PH_BODY        = 4'd8;

   localparam logic [STATUS_W-1:0]      STATUS_MAX = '1;
   localparam logic [BODY_LEN_BITS-1:0] BODY_MAX   = '1;

   // Parse state.
   logic [3:0]               phase_ff, phase_in;
   logic [STATUS_W-1:0]      status_acc_ff, status_acc_in;
   logic                     prev_was_cr_ff, prev_was_cr_in;
   logic [3:0]               name_pos_ff, name_pos_in;
   logic [CTYPE_LEN_W-1:0]   value_count_ff, value_count_in;
   logic [BODY_LEN_BITS-1:0] body_count_ff, body_count_in;
   logic                     text_ended_ff, text_ended_in;

   // Result queue.
   result_type fifo_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic                   emit;
   logic [KIND_W-1:0]      emit_kind;
   logic [CTYPE_LEN_W-1:0] emit_index;
   logic                   is_digit;
   logic                   in_value;
   logic [19:0]            status_wide;
   logic [1:0]             n_wr;
   result_type             byte_res;
   result_type             summary_res;
   result_type             first_res;
   result_type             head_res;

   assign req_ready = (count_ff <= 3'd2);
   assign rsp_valid = (count_ff != 3'd0);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   assign is_digit    = (req_data_byte >= ZERO_CHAR) && (req_data_byte <= NINE_CHAR);
   assign status_wide = {1'b0, status_acc_ff, 3'b000} + {3'b000, status_acc_ff, 1'b0}
                      + {16'd0, 4'(req_data_byte - ZERO_CHAR)};
   assign in_value    = (phase_ff == PH_VALUE)
                     || ((phase_ff == PH_SPACES) && (req_data_byte != SPACE_BYTE));

   // Next parse state for one byte.
   always_comb begin
      phase_in       = phase_ff;
      status_acc_in  = status_acc_ff;
      prev_was_cr_in = prev_was_cr_ff;
      name_pos_in    = name_pos_ff;
      value_count_in = value_count_ff;
      body_count_in  = body_count_ff;
      text_ended_in  = text_ended_ff;
      emit           = 1'b0;
      emit_kind      = KIND_CTYPE;
      emit_index     = '0;
      if (!text_ended_ff) begin
         if (req_data_byte == 8'd0) begin
            text_ended_in = 1'b1;
         end else if (in_value) begin
            // Content-type value bytes, up to the CR or the length cap.
            phase_in = PH_VALUE;
            if (req_data_byte == CR_BYTE) begin
               phase_in       = PH_LINE_REST;
               prev_was_cr_in = 1'b1;
            end else if (value_count_ff < CTYPE_MAX) begin
               emit           = 1'b1;
               emit_index     = value_count_ff;
               value_count_in = value_count_ff + 8'd1;
            end else begin
               phase_in       = PH_LINE_REST;
               prev_was_cr_in = 1'b0;
            end
         end else begin
            unique case (phase_ff)
               PH_VERSION: begin
                  if (req_data_byte == SPACE_BYTE) begin
                     phase_in       = PH_DIGITS;
                     prev_was_cr_in = 1'b0;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     status_acc_in = (status_wide > {4'd0, STATUS_MAX})
                                   ? STATUS_MAX : status_wide[STATUS_W-1:0];
                  end else if (req_data_byte == LF_BYTE && prev_was_cr_ff) begin
                     phase_in       = PH_NAME;
                     name_pos_in    = '0;
                     prev_was_cr_in = 1'b0;
                  end else begin
                     phase_in       = PH_STATUS_REST;
                     prev_was_cr_in = (req_data_byte == CR_BYTE);
                  end
               end
               PH_STATUS_REST, PH_LINE_REST: begin
                  // Look for the CR LF that ends the line.
                  if (req_data_byte == LF_BYTE && prev_was_cr_ff) begin
                     phase_in       = PH_NAME;
                     name_pos_in    = '0;
                     prev_was_cr_in = 1'b0;
                  end else begin
                     prev_was_cr_in = (req_data_byte == CR_BYTE);
                  end
               end
               PH_NAME: begin
                  if (name_pos_ff == 4'd0 && req_data_byte == CR_BYTE) begin
                     phase_in = PH_LINE_CR;
                  end else if (name_pos_ff < NAME_LEN
                               && req_data_byte == name_char(name_pos_ff)) begin
                     name_pos_in = name_pos_ff + 4'd1;
                     if (name_pos_ff + 4'd1 == NAME_LEN) begin
                        phase_in       = PH_SPACES;
                        value_count_in = '0;
                     end
                  end else begin
                     phase_in       = PH_LINE_REST;
                     prev_was_cr_in = (req_data_byte == CR_BYTE);
                  end
               end
               PH_LINE_CR: begin
                  if (req_data_byte == LF_BYTE) begin
                     phase_in       = PH_BODY;
                     prev_was_cr_in = 1'b0;
                  end else begin
                     phase_in       = PH_LINE_REST;
                     prev_was_cr_in = (req_data_byte == CR_BYTE);
                  end
               end
               PH_SPACES: begin
                  // A leading space is skipped; other bytes go to the value path.
               end
               PH_BODY: begin
                  if (body_count_ff != BODY_MAX) begin
                     body_count_in = body_count_ff + BODY_LEN_BITS'(1);
                  end
                  emit      = 1'b1;
                  emit_kind = KIND_BODY;
               end
               default: begin
                  phase_in = PH_VERSION;
               end
            endcase
         end
      end

      // The summary sees the state after this byte; then everything restarts.
      summary_res.kind         = KIND_SUMMARY;
      summary_res.out_byte     = '0;
      summary_res.ctype_index  = '0;
      summary_res.status_code  = status_acc_in;
      summary_res.ctype_length = value_count_in;
      summary_res.body_length  = body_count_in;
      summary_res.ok           = (phase_in == PH_BODY);
      summary_res.run_end      = 1'b1;

      if (req_last) begin
         phase_in       = PH_VERSION;
         status_acc_in  = '0;
         prev_was_cr_in = 1'b0;
         name_pos_in    = '0;
         value_count_in = '0;
         body_count_in  = '0;
         text_ended_in  = 1'b0;
      end
   end

   // Results written to the queue for this transaction.
   always_comb begin
      byte_res              = '0;
      byte_res.kind         = emit_kind;
      byte_res.out_byte     = req_data_byte;
      byte_res.ctype_index  = emit_index;
      byte_res.run_end      = !req_last;
      first_res             = emit ? byte_res : summary_res;
      n_wr                  = {1'b0, emit} + {1'b0, req_last};
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + n_wr;
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
      end
      count_in = count_ff + (req_fire ? {1'b0, n_wr} : 3'd0) - {2'b00, rsp_fire};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_VERSION;
         status_acc_ff  <= '0;
         prev_was_cr_ff <= 1'b0;
         name_pos_ff    <= '0;
         value_count_ff <= '0;
         body_count_ff  <= '0;
         text_ended_ff  <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (req_fire) begin
            phase_ff       <= phase_in;
            status_acc_ff  <= status_acc_in;
            prev_was_cr_ff <= prev_was_cr_in;
            name_pos_ff    <= name_pos_in;
            value_count_ff <= value_count_in;
            body_count_ff  <= body_count_in;
            text_ended_ff  <= text_ended_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; a summary after a byte result takes the following slot.
   always_ff @(posedge clock) begin
      if (req_fire && n_wr != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= first_res;
      end
      if (req_fire && n_wr == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= summary_res;
      end
   end

   // Head of the queue drives the result ports.
   assign head_res         = fifo_ff[rd_ptr_ff];
   assign rsp_kind         = head_res.kind;
   assign rsp_out_byte     = head_res.out_byte;
   assign rsp_ctype_index  = head_res.ctype_index;
   assign rsp_status_code  = head_res.status_code;
   assign rsp_ctype_length = head_res.ctype_length;
   assign rsp_body_length  = head_res.body_length;
   assign rsp_ok           = head_res.ok;
   assign rsp_run_end      = head_res.run_end;

   // The queue never holds more than its four entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overfilled");

   // A last byte leaves the parser back at the version field with cleared counters.
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last |=> phase_ff == PH_VERSION && body_count_ff == '0
                               && value_count_ff == '0 && !text_ended_ff)
      else $error("parse state not restarted after last byte");

   // Once the text has ended, a byte that is not last yields no result.
   a_ended_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && text_ended_ff && !req_last
      |=> count_ff == $past(count_ff) - {2'b00, $past(rsp_fire)})
      else $error("result produced after end of text");

endmodule

FILE: verif/response_ledger_pkg.sv
package response_ledger_pkg;

   import hrhp_pkg::*;

   // Header name that selects a value, first character in the top byte.
   localparam logic [13*8-1:0] CT_NAME = "Content-Type:";

   // Byte that ends the response text.
   localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;

   // Largest status number that the block keeps.
   localparam int unsigned STATUS_MAX = 65535;

   // Number of mismatch lines shown before the rest are only counted.
   localparam int unsigned MAX_SHOWN = 40;

   // Where the parser is within one response.
   typedef enum logic [3:0] {
      VERSION_SKIP,
      STATUS_DIGITS,
      STATUS_TAIL,
      NAME_MATCH,
      BLANK_CR,
      LINE_TAIL,
      VALUE_SPACES,
      VALUE_BYTES,
      BODY_BYTES
   } parse_phase_type;

   // Character of the matched header name at a given position.
   function automatic logic [BYTE_W-1:0] name_at(int pos);
      return CT_NAME[8*(12-pos) +: 8];
   endfunction

   // Tracks the parse of each response and holds the results still owed.
   class response_ledger_type;

      parse_phase_type          phase;
      int unsigned              status_acc;
      bit                       prev_cr;
      int unsigned              name_pos;
      logic [CTYPE_LEN_W-1:0]   value_count;
      logic [BODY_LEN_BITS-1:0] body_count;
      bit                       text_ended;
      result_type               expected_results[$];
      int unsigned              errors;

      function new();
         errors = 0;
         restart();
      endfunction

      // State at the start of every response.
      function void restart();
         phase       = VERSION_SKIP;
         status_acc  = 0;
         prev_cr     = 1'b0;
         name_pos    = 0;
         value_count = '0;
         body_count  = '0;
         text_ended  = 1'b0;
      endfunction

      // Looks for the CR LF pair that closes a line.
      function void scan_line(logic [BYTE_W-1:0] b);
         if (b == LF_BYTE && prev_cr) begin
            phase    = NAME_MATCH;
            name_pos = 0;
            prev_cr  = 1'b0;
         end else begin
            prev_cr = (b == CR_BYTE);
         end
      endfunction

      // Advances the parse by one nonzero byte; returns 1 when the byte is passed on.
      function bit parse_byte(logic [BYTE_W-1:0] b, output logic [KIND_W-1:0] kind_o,
                              output logic [CTYPE_LEN_W-1:0] index_o);
         int unsigned acc;
         bit          taken;
         taken   = 1'b0;
         kind_o  = KIND_BODY;
         index_o = '0;
         case (phase)
            VERSION_SKIP: begin
               if (b == SPACE_BYTE) begin
                  phase   = STATUS_DIGITS;
                  prev_cr = 1'b0;
               end
            end
            STATUS_DIGITS: begin
               if (b >= ZERO_CHAR && b <= NINE_CHAR) begin
                  acc        = status_acc * 10 + int'(b - ZERO_CHAR);
                  status_acc = (acc > STATUS_MAX) ? STATUS_MAX : acc;
               end else begin
                  phase = STATUS_TAIL;
                  scan_line(b);
               end
            end
            STATUS_TAIL, LINE_TAIL: begin
               scan_line(b);
            end
            NAME_MATCH: begin
               if (name_pos == 0 && b == CR_BYTE) begin
                  phase = BLANK_CR;
               end else if (name_pos < NAME_LEN && b == name_at(name_pos)) begin
                  name_pos++;
                  if (name_pos == NAME_LEN) begin
                     phase       = VALUE_SPACES;
                     value_count = '0;
                  end
               end else begin
                  phase   = LINE_TAIL;
                  prev_cr = (b == CR_BYTE);
               end
            end
            BLANK_CR: begin
               if (b == LF_BYTE) begin
                  phase   = BODY_BYTES;
                  prev_cr = 1'b0;
               end else begin
                  phase   = LINE_TAIL;
                  prev_cr = (b == CR_BYTE);
               end
            end
            VALUE_SPACES, VALUE_BYTES: begin
               // Leading spaces are dropped; the first other byte opens the value.
               if (!(phase == VALUE_SPACES && b == SPACE_BYTE)) begin
                  phase = VALUE_BYTES;
                  if (b == CR_BYTE) begin
                     phase   = LINE_TAIL;
                     prev_cr = 1'b1;
                  end else if (value_count < CTYPE_MAX) begin
                     kind_o  = KIND_CTYPE;
                     index_o = value_count;
                     value_count++;
                     taken   = 1'b1;
                  end else begin
                     phase   = LINE_TAIL;
                     prev_cr = 1'b0;
                  end
               end
            end
            BODY_BYTES: begin
               if (body_count != '1) begin
                  body_count++;
               end
               taken = 1'b1;
            end
            default: begin
               phase = VERSION_SKIP;
            end
         endcase
         return taken;
      endfunction

      // Works out the results of one accepted input transaction.
      function void note_byte(logic [BYTE_W-1:0] b, logic last);
         result_type             r;
         logic [KIND_W-1:0]      kind_v;
         logic [CTYPE_LEN_W-1:0] index_v;
         int unsigned            made;
         made = 0;
         if (!text_ended) begin
            if (b == NUL_BYTE) begin
               text_ended = 1'b1;
            end else if (parse_byte(b, kind_v, index_v)) begin
               r             = '0;
               r.kind        = kind_v;
               r.out_byte    = b;
               r.ctype_index = index_v;
               expected_results.push_back(r);
               made++;
            end
         end
         if (last) begin
            r              = '0;
            r.kind         = KIND_SUMMARY;
            r.status_code  = status_acc[STATUS_W-1:0];
            r.ctype_length = value_count;
            r.body_length  = body_count;
            r.ok           = (phase == BODY_BYTES);
            expected_results.push_back(r);
            made++;
            restart();
         end
         if (made != 0) begin
            expected_results[expected_results.size() - 1].run_end = 1'b1;
         end
      endfunction

      function int unsigned pending();
         return expected_results.size();
      endfunction

      task report(string msg);
         if (errors < MAX_SHOWN) begin
            $display("parser mismatch at %0t: %s", $time, msg);
         end
         errors++;
      endtask

      task check_field(string name, longint unsigned got_v, longint unsigned want_v);
         if (got_v != want_v) begin
            report($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
         end
      endtask

      // Compares one accepted result transaction with the oldest one owed.
      task check_result(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("unexpected result of kind %0d", got.kind));
         end else begin
            want = expected_results.pop_front();
            check_field("kind", got.kind, want.kind);
            check_field("out_byte", got.out_byte, want.out_byte);
            check_field("ctype_index", got.ctype_index, want.ctype_index);
            check_field("status_code", got.status_code, want.status_code);
            check_field("ctype_length", got.ctype_length, want.ctype_length);
            check_field("body_length", got.body_length, want.body_length);
            check_field("ok", got.ok, want.ok);
            check_field("run_end", got.run_end, want.run_end);
         end
      endtask

   endclass

endpackage

FILE: verif/tb_top.sv
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import hrhp_pkg::*;
   import response_ledger_pkg::*;

   localparam int unsigned CLK_PERIOD   = 10;
   localparam int unsigned RESET_CYCLES = 12;
   localparam int unsigned ITEM_TARGET  = 1450;
   localparam int unsigned QUIET_FROM   = 1250;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [BYTE_W-1:0]        req_data_byte = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [KIND_W-1:0]        rsp_kind;
   logic [BYTE_W-1:0]        rsp_out_byte;
   logic [CTYPE_LEN_W-1:0]   rsp_ctype_index;
   logic [STATUS_W-1:0]      rsp_status_code;
   logic [CTYPE_LEN_W-1:0]   rsp_ctype_length;
   logic [BODY_LEN_BITS-1:0] rsp_body_length;
   logic                     rsp_ok;
   logic                     rsp_run_end;
   result_type               rsp_seen;

   response_ledger_type ledger = new();
   logic [BYTE_W-1:0]   resp_q[$];
   int unsigned         items_sent = 0;
   int unsigned         cycle_count = 0;
   bit                  quiet = 1'b0;
   bit                  hold_request = 1'b0;
   int unsigned         hold_left = 0;
   int unsigned         burst_left = 0;
   bit                  burst_stall = 1'b0;

   http_response_header_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_ctype_index  (rsp_ctype_index),
      .rsp_status_code  (rsp_status_code),
      .rsp_ctype_length (rsp_ctype_length),
      .rsp_body_length  (rsp_body_length),
      .rsp_ok           (rsp_ok),
      .rsp_run_end      (rsp_run_end)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   assign rsp_seen = {rsp_kind, rsp_out_byte, rsp_ctype_index, rsp_status_code,
                      rsp_ctype_length, rsp_body_length, rsp_ok, rsp_run_end};

   // Both channels are sampled at the rising edge; inputs are noted before results are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            ledger.note_byte(req_data_byte, req_last);
         end
         if (rsp_valid && rsp_ready) begin
            ledger.check_result(rsp_seen);
         end
      end
   end

   // Result side: random stall bursts, a long hold-off on request, none in the closing part.
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (quiet || reset) begin
         rsp_ready <= 1'b1;
      end else begin
         if (burst_left == 0) begin
            burst_stall = ($urandom_range(0, 2) == 0);
            burst_left  = burst_stall ? $urandom_range(1, 18) : $urandom_range(1, 40);
         end
         burst_left--;
         rsp_ready <= !burst_stall;
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Random nonzero header text; mostly printable, now and then any byte.
   function automatic logic [BYTE_W-1:0] text_byte(bit allow_cr);
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 5) == 0) begin
         do begin
            b = 8'($urandom);
         end while (b == NUL_BYTE || (!allow_cr && b == CR_BYTE));
      end else begin
         b = 8'($urandom_range(8'h21, 8'h7e));
      end
      return b;
   endfunction

   // Appends one header line of a random form.
   function automatic void add_header(bit long_value);
      int unsigned form, n, p;
      form = long_value ? 0 : $urandom_range(0, 5);
      case (form)
         0, 1, 2: begin
            for (int i = 0; i < NAME_LEN; i++) resp_q.push_back(name_at(i));
            n = $urandom_range(0, 3);
            repeat (n) resp_q.push_back(SPACE_BYTE);
            n = long_value ? $urandom_range(250, 300) : $urandom_range(0, 12);
            repeat (n) resp_q.push_back(text_byte(1'b0));
            // Now and then the value runs on into the next line.
            if ($urandom_range(0, 7) == 0) begin
               return;
            end
         end
         3: begin
            // A name that breaks off part way, by flipping bit 5 of the next character (its case, for a letter).
            p = $urandom_range(1, 12);
            for (int i = 0; i < p; i++) resp_q.push_back(name_at(i));
            resp_q.push_back(name_at(p) ^ 8'h20);
            n = $urandom_range(0, 8);
            repeat (n) resp_q.push_back(text_byte(1'b0));
         end
         4: begin
            n = $urandom_range(1, 15);
            repeat (n) resp_q.push_back(text_byte(1'b0));
         end
         default: begin
            // Lone CRs, at the start of the line or within it.
            if ($urandom_range(0, 1) == 0) begin
               resp_q.push_back(CR_BYTE);
            end
            resp_q.push_back(text_byte(1'b0));
            resp_q.push_back(CR_BYTE);
            n = $urandom_range(1, 6);
            repeat (n) resp_q.push_back(text_byte(1'b0));
         end
      endcase
      resp_q.push_back(CR_BYTE);
      resp_q.push_back(LF_BYTE);
   endfunction

   // Builds one response: mostly well formed, with noise, missing parts and truncation.
   function automatic void build_response(int unsigned serial);
      int unsigned shape, n, cut;
      resp_q.delete();
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         n = $urandom_range(1, 30);
         repeat (n) resp_q.push_back(8'($urandom));
         return;
      end
      n = $urandom_range(0, 8);
      repeat (n) resp_q.push_back(text_byte(1'b1));
      if (shape != 1) begin
         resp_q.push_back(SPACE_BYTE);
      end
      n = (serial % 7 == 4) ? $urandom_range(6, 9) : $urandom_range(0, 4);
      repeat (n) resp_q.push_back(ZERO_CHAR + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) == 0) begin
         resp_q.push_back(SPACE_BYTE);
         n = $urandom_range(0, 6);
         repeat (n) resp_q.push_back(text_byte(1'b0));
      end
      resp_q.push_back(CR_BYTE);
      resp_q.push_back(LF_BYTE);
      n = $urandom_range(0, 4);
      if (serial % 5 == 3 && n == 0) begin
         n = 1;
      end
      for (int h = 0; h < n; h++) add_header(serial % 5 == 3 && h == 0);
      if (shape != 2) begin
         resp_q.push_back(CR_BYTE);
         resp_q.push_back(LF_BYTE);
      end
      n = $urandom_range(0, 24);
      repeat (n) resp_q.push_back(8'($urandom_range(1, 255)));
      if (shape == 3) begin
         resp_q.insert($urandom_range(0, resp_q.size()), NUL_BYTE);
      end
      if (shape == 4) begin
         cut = $urandom_range(1, resp_q.size());
         while (resp_q.size() > cut) void'(resp_q.pop_back());
      end
   endfunction

   // Idles the request side with junk on the payload.
   task automatic idle_sender(int unsigned n);
      @(negedge clock);
      req_valid     <= 1'b0;
      req_data_byte <= 8'($urandom);
      req_last      <= 1'($urandom);
      repeat (n - 1) @(negedge clock);
   endtask

   // Sends the built response, one transaction per byte, marking the final byte.
   task automatic send_response(bit allow_gaps);
      for (int i = 0; i < resp_q.size(); i++) begin
         if (allow_gaps && !quiet && $urandom_range(0, 5) == 0) begin
            idle_sender($urandom_range(1, 18));
         end
         @(negedge clock);
         req_valid     <= 1'b1;
         req_data_byte <= resp_q[i];
         req_last      <= (i == resp_q.size() - 1);
         do @(posedge clock); while (!req_ready);
         items_sent++;
      end
   endtask

   initial begin
      int unsigned serial;
      bit          hold;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Short fixed responses: a body byte on the final byte, a bare end of text,
      // a lone CR with bytes after the end, and a status that overflows.
      resp_q = '{8'hff, SPACE_BYTE, NINE_CHAR, CR_BYTE, LF_BYTE, CR_BYTE, LF_BYTE, 8'hff};
      send_response(1'b1);
      resp_q = '{NUL_BYTE};
      send_response(1'b1);
      resp_q = '{SPACE_BYTE, 8'h35, CR_BYTE, 8'h78, CR_BYTE, LF_BYTE, CR_BYTE, LF_BYTE,
                 8'h80, NUL_BYTE, 8'h7f};
      send_response(1'b1);
      resp_q = '{SPACE_BYTE, 8'h37, ZERO_CHAR, ZERO_CHAR, ZERO_CHAR, ZERO_CHAR};
      send_response(1'b1);

      // Random responses; two of them run under a long hold-off on the result side.
      serial = 0;
      while (items_sent < ITEM_TARGET) begin
         build_response(serial);
         hold = (serial == 2 || serial == 9);
         if (hold) begin
            hold_request = 1'b1;
         end
         quiet = (items_sent >= QUIET_FROM);
         send_response(!hold);
         serial++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/hrhp_pkg.sv
hdl/http_response_header_parser.sv
verif/response_ledger_pkg.sv
verif/tb_top.sv
